>>> rtl/lbf_pkg.sv
`default_nettype none
// shared types and constants of the lorentz boost pipeline
package lbf_pkg;

    // field and limb widths
    localparam int WORD_W  = 32;
    localparam int LIMB_W  = 32;
    localparam int IN_W    = 11 * WORD_W;
    localparam int OUT_W   = 8 * WORD_W;

    // reciprocal unit: divisor width and quotient bits
    localparam int DIV_W   = 33;
    localparam int RECIP_W = 64;

    // square root steps, one result bit each
    localparam int SQ_STEPS = 32;

    // datapath widths of the boost
    localparam int DOT_W  = 66;
    localparam int T_W    = 67;
    localparam int GT_W   = RECIP_W + T_W;
    localparam int KD_W   = RECIP_W + DOT_W;
    localparam int GA_W   = RECIP_W + WORD_W;
    localparam int DIFF_W = 131;
    localparam int FRAC_SH  = 46;
    localparam int GAMMA_SH = 62;
    localparam int A0_SH    = 30;
    localparam int C_W    = DIFF_W - FRAC_SH;
    localparam int CV_W   = C_W + WORD_W;
    localparam int SUM_W  = 72;

    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

    // two four-vectors: index 0 momentum, index 1 coordinates
    typedef logic [1:0][3:0][WORD_W-1:0] t_vecs;
    typedef logic [2:0][WORD_W-1:0] t_vel;

    // data that rides along the pipeline beside the math
    typedef struct packed {
        t_vecs                 vec;
        t_vel                  vel;
        logic [1:0][DOT_W-1:0] dot;
        logic                  zero;
        logic                  inv;
    } t_side;

endpackage
`default_nettype wire

>>> rtl/lbf_mul.sv
`default_nettype none
// pipelined wide signed multiplier built from 33x33 limb products
module lbf_mul
    import lbf_pkg::*;
#(
    parameter int WA = 64,
    parameter int WB = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_ce,
    input  wire logic signed [WA-1:0]  i_a,
    input  wire logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0]    o_p
);
    localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int WP = LIMB_W * (NA + NB);

    logic signed [NA*LIMB_W-1:0] a_ext;
    logic signed [NB*LIMB_W-1:0] b_ext;
    logic signed [LIMB_W:0]      a_limb [NA];
    logic signed [LIMB_W:0]      b_limb [NB];
    logic signed [2*LIMB_W+1:0]  r_pp [NA][NB];
    logic signed [WP-1:0]        r_row [NA];
    logic signed [WP-1:0]        n_row [NA];
    logic signed [WP-1:0]        r_sum;
    logic signed [WP-1:0]        n_sum;

    assign a_ext = (NA*LIMB_W)'(i_a);
    assign b_ext = (NB*LIMB_W)'(i_b);

    // lower limbs unsigned, top limb signed
    for (genvar j = 0; j < NA; j++) begin : g_alimb
        if (j == NA - 1) begin : g_top
            assign a_limb[j] = {a_ext[LIMB_W*(j+1)-1], a_ext[LIMB_W*j +: LIMB_W]};
        end else begin : g_low
            assign a_limb[j] = {1'b0, a_ext[LIMB_W*j +: LIMB_W]};
        end
    end
    for (genvar k = 0; k < NB; k++) begin : g_blimb
        if (k == NB - 1) begin : g_top
            assign b_limb[k] = {b_ext[LIMB_W*(k+1)-1], b_ext[LIMB_W*k +: LIMB_W]};
        end else begin : g_low
            assign b_limb[k] = {1'b0, b_ext[LIMB_W*k +: LIMB_W]};
        end
    end

    // partial product stage
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < NA; j++) begin
                for (int k = 0; k < NB; k++) begin
                    r_pp[j][k] <= a_limb[j] * b_limb[k];
                end
            end
        end
    end

    // row sums
    always_comb begin
        for (int j = 0; j < NA; j++) begin
            n_row[j] = '0;
            for (int k = 0; k < NB; k++) begin
                n_row[j] = n_row[j] + (WP'(r_pp[j][k]) <<< (LIMB_W * k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_row <= n_row;
        end
    end

    // final sum of rows
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < NA; j++) begin
            n_sum = n_sum + (r_row[j] <<< (LIMB_W * j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[WA+WB-1:0];

endmodule
`default_nettype wire

>>> rtl/lbf_recip.sv
`default_nettype none
// pipelined floor(2^64 / x), one quotient bit per stage
module lbf_recip
    import lbf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_ce,
    input  wire logic [DIV_W-1:0]   i_x,
    output logic [RECIP_W-1:0]      o_q
);
    localparam int REM_W = DIV_W + 1;

    logic [REM_W-1:0]   r_rem [RECIP_W-1];
    logic [DIV_W-1:0]   r_x   [RECIP_W-1];
    logic [RECIP_W-1:0] r_q   [RECIP_W];

    for (genvar i = 0; i < RECIP_W; i++) begin : g_step
        logic [REM_W-1:0]   rem_in;
        logic [DIV_W-1:0]   x_in;
        logic [RECIP_W-1:0] q_in;
        logic [REM_W-1:0]   rem_sh;
        logic               fit;

        // the leading dividend bit leaves a remainder of one
        if (i == 0) begin : g_first
            assign rem_in = REM_W'(1);
            assign x_in   = i_x;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign x_in   = r_x[i-1];
            assign q_in   = r_q[i-1];
        end

        assign rem_sh = {rem_in[REM_W-2:0], 1'b0};
        assign fit    = rem_sh >= {1'b0, x_in};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[i] <= {q_in[RECIP_W-2:0], fit};
            end
        end

        if (i < RECIP_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[i] <= fit ? rem_sh - {1'b0, x_in} : rem_sh;
                    r_x[i]   <= x_in;
                end
            end
        end
    end

    assign o_q = r_q[RECIP_W-1];

endmodule
`default_nettype wire

>>> rtl/lorentz_boost_four_vectors.sv
`default_nettype none
// top level of the general-direction lorentz boost pipeline
//
// Boosts a momentum four-vector and a space-time four-vector (Q16.16) by a
// velocity (Q2.30). Takes one beat per cycle unless the output stalls; the
// pipeline depth comes from the 32-stage square root of 1 - v^2 and the two
// 64-stage reciprocals that give gamma and (gamma - 1) / v^2, followed by
// limb-split multipliers. The whole pipeline advances when the output
// register is empty or taken, so a stall at the output holds every stage. A
// zero velocity passes the inputs through; a velocity of one or more gives
// zeros with the invalid flag in tuser.
// boost_coordinates selects whether the second four-vector is boosted too.
module lorentz_boost_four_vectors
    import lbf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // config register boost_coordinates
    input  wire logic              i_cfg_wen,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // energy_in, mom_x_in, mom_y_in, mom_z_in, time_in, pos_x_in, pos_y_in,
    // pos_z_in, vel_x, vel_y, vel_z
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // energy_out, mom_x_out, mom_y_out, mom_z_out, time_out, pos_x_out,
    // pos_y_out, pos_z_out
    output logic [OUT_W-1:0]       o_m_axis_tdata,
    // invalid
    output logic                   o_m_axis_tuser
);
    localparam int MID_LEN = SQ_STEPS + 2 + RECIP_W;
    localparam int ST_X1   = 3 + MID_LEN;
    localparam int BS_LEN  = 9;
    localparam int LAT     = ST_X1 + BS_LEN + 1;

    function automatic logic [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic [WORD_W-1:0] res;
        if ((&x[SUM_W-1:WORD_W-1]) || !(|x[SUM_W-1:WORD_W-1])) begin
            res = x[WORD_W-1:0];
        end else if (x[SUM_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic ce;
    logic r_boost_coords;
    logic [LAT-1:0] r_vld;

    t_vecs s_vec;
    t_vel  s_vel;

    t_vecs              r_a_vec;
    t_vel               r_a_vel;
    logic [63:0]        r_a_sq [3];
    logic signed [63:0] r_a_dp [2][3];

    t_side       r_b, n_b;
    logic [63:0] r_b_v2;
    t_side       r_c, n_c;
    logic [63:0] r_c_rad;

    logic [63:0] r_sq_root [SQ_STEPS];
    logic [63:0] r_sq_rad  [SQ_STEPS-1];

    logic [WORD_W-1:0]  r_e_s, r_f_s;
    logic [63:0]        r_e_ss;
    logic [DIV_W-1:0]   r_f_d;
    logic [RECIP_W-1:0] g_q, k_q;

    t_side r_mid [MID_LEN];

    t_side                r_x1;
    logic [RECIP_W-1:0]   r_x1_g, r_x1_k;
    logic signed [T_W-1:0] r_x1_t [2];

    logic signed [GT_W-1:0]   gt_p [2];
    logic signed [KD_W-1:0]   kd_p [2];
    logic signed [GA_W-1:0]   ga_p [2];
    logic signed [DIFF_W-1:0] c_diff [2];
    logic signed [C_W-1:0]    r_x5_c [2];
    logic signed [CV_W-1:0]   cv_p [2][3];
    logic signed [SUM_W-1:0]  r_x9_sum [2][3];
    logic [WORD_W-1:0]        r_tm [2][5];
    t_vecs                    r_res;
    t_side                    r_bs [BS_LEN];

    t_vecs r_out_data, n_out_data;
    logic  r_out_inv, n_out_inv, r_out_vld;

    // the whole pipeline moves when the output register can take a beat
    assign ce = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    assign s_vec = i_s_axis_tdata[8*WORD_W-1:0];
    assign s_vel = i_s_axis_tdata[IN_W-1:8*WORD_W];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_coords <= 1'b1;
        end else if (i_cfg_wen) begin
            r_boost_coords <= i_cfg_wdata;
        end
    end

    // valid bits alongside the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_vld     <= {r_vld[LAT-2:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    // stage a: squares of the velocity and products for the dot products
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_vec <= s_vec;
            r_a_vel <= s_vel;
            for (int i = 0; i < 3; i++) begin
                r_a_sq[i] <= $signed(s_vel[i]) * $signed(s_vel[i]);
                for (int u = 0; u < 2; u++) begin
                    r_a_dp[u][i] <= $signed(s_vel[i]) * $signed(s_vec[u][i+1]);
                end
            end
        end
    end

    // stage b: v^2 and the two dot products
    always_comb begin
        n_b      = '0;
        n_b.vec  = r_a_vec;
        n_b.vel  = r_a_vel;
        for (int u = 0; u < 2; u++) begin
            n_b.dot[u] = DOT_W'(r_a_dp[u][0]) + DOT_W'(r_a_dp[u][1])
                       + DOT_W'(r_a_dp[u][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_b    <= n_b;
            r_b_v2 <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
        end
    end

    // stage c: special cases and the root radicand 16 * (1 - v^2)
    always_comb begin
        n_c      = r_b;
        n_c.zero = (r_b_v2 == '0);
        n_c.inv  = |r_b_v2[63:60];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c     <= n_c;
            r_c_rad <= (ONE_Q60 - r_b_v2) << 4;
        end
    end

    // square root, one result bit per stage
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
        logic [63:0] rad_in;
        logic [63:0] root_in;
        logic [63:0] trial;
        logic        fit;

        if (i == 0) begin : g_first
            assign rad_in  = r_c_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_sq_rad[i-1];
            assign root_in = r_sq_root[i-1];
        end

        assign trial = root_in + BIT;
        assign fit   = rad_in >= trial;

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_sq_root[i] <= fit ? (root_in >> 1) + BIT : root_in >> 1;
            end
        end

        if (i < SQ_STEPS - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_sq_rad[i] <= fit ? rad_in - trial : rad_in;
                end
            end
        end
    end

    // s*s, then the divisor s + s*s / 2^32 for (gamma - 1) / v^2
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_e_s  <= r_sq_root[SQ_STEPS-1][WORD_W-1:0];
            r_e_ss <= r_sq_root[SQ_STEPS-1][WORD_W-1:0] * r_sq_root[SQ_STEPS-1][WORD_W-1:0];
            r_f_s  <= r_e_s;
            r_f_d  <= {1'b0, r_e_s} + {1'b0, r_e_ss[63:32]};
        end
    end

    lbf_recip u_recip_g (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_x   ({1'b0, r_f_s}),
        .o_q   (g_q)
    );

    lbf_recip u_recip_k (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_x   (r_f_d),
        .o_q   (k_q)
    );

    // side data delayed over root and reciprocals
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mid[0] <= r_c;
            for (int j = 1; j < MID_LEN; j++) begin
                r_mid[j] <= r_mid[j-1];
            end
        end
    end

    // stage x1: t = a0 * 2^30 - v.a
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_x1   <= r_mid[MID_LEN-1];
            r_x1_g <= g_q;
            r_x1_k <= k_q;
            for (int u = 0; u < 2; u++) begin
                r_x1_t[u] <= (T_W'($signed(r_mid[MID_LEN-1].vec[u][0])) <<< A0_SH)
                           - T_W'($signed(r_mid[MID_LEN-1].dot[u]));
            end
        end
    end

    // side data over the boost stages
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_bs[0] <= r_x1;
            for (int j = 1; j < BS_LEN; j++) begin
                r_bs[j] <= r_bs[j-1];
            end
        end
    end

    for (genvar u = 0; u < 2; u++) begin : g_vec
        // gamma * t, k * (v.a), gamma * a0
        lbf_mul #(.WA(RECIP_W), .WB(T_W)) u_gt (
            .i_clk (i_clk),
            .i_ce  (ce),
            .i_a   ($signed(r_x1_g)),
            .i_b   (r_x1_t[u]),
            .o_p   (gt_p[u])
        );

        lbf_mul #(.WA(RECIP_W), .WB(DOT_W)) u_kd (
            .i_clk (i_clk),
            .i_ce  (ce),
            .i_a   ($signed(r_x1_k)),
            .i_b   ($signed(r_x1.dot[u])),
            .o_p   (kd_p[u])
        );

        lbf_mul #(.WA(RECIP_W), .WB(WORD_W)) u_ga (
            .i_clk (i_clk),
            .i_ce  (ce),
            .i_a   ($signed(r_x1_g)),
            .i_b   ($signed(r_x1.vec[u][0])),
            .o_p   (ga_p[u])
        );

        // c = k*(v.a) - gamma*a0*2^30, floored to Q.32
        assign c_diff[u] = DIFF_W'(kd_p[u]) - (DIFF_W'(ga_p[u]) <<< A0_SH);

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_x5_c[u]  <= c_diff[u][DIFF_W-1:FRAC_SH];
                r_tm[u][0] <= sat32(SUM_W'($signed(gt_p[u][GT_W-1:GAMMA_SH])));
                for (int j = 1; j < 5; j++) begin
                    r_tm[u][j] <= r_tm[u][j-1];
                end
            end
        end

        // space parts: floor(c * v_i / 2^46) + a_i
        for (genvar i = 0; i < 3; i++) begin : g_axis
            lbf_mul #(.WA(C_W), .WB(WORD_W)) u_cv (
                .i_clk (i_clk),
                .i_ce  (ce),
                .i_a   (r_x5_c[u]),
                .i_b   ($signed(r_bs[3].vel[i])),
                .o_p   (cv_p[u][i])
            );

            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_x9_sum[u][i] <= SUM_W'($signed(cv_p[u][i][CV_W-1:FRAC_SH]))
                                    + SUM_W'($signed(r_bs[6].vec[u][i+1]));
                    r_res[u][i+1]  <= sat32(r_x9_sum[u][i]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_res[u][0] <= r_tm[u][4];
            end
        end
    end

    // result select
    always_comb begin
        n_out_data = r_bs[BS_LEN-1].vec;
        n_out_inv  = 1'b0;
        if (r_bs[BS_LEN-1].inv) begin
            n_out_data = '0;
            n_out_inv  = 1'b1;
        end else if (!r_bs[BS_LEN-1].zero) begin
            n_out_data[0] = r_res[0];
            if (r_boost_coords) begin
                n_out_data[1] = r_res[1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_data <= n_out_data;
            r_out_inv  <= n_out_inv;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_inv;

    // an invalid beat carries all zeros
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("invalid beat with nonzero data");

    // gamma lies in [2^32, 2^63) for a regular velocity
    a_gamma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_X1] && !r_x1.zero && !r_x1.inv
        |-> !r_x1_g[RECIP_W-1] && (r_x1_g[RECIP_W-2:WORD_W] != '0))
        else $error("gamma out of range");

    // a stall freezes the valid bits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

>>> verif/tb_lorentz_boost_four_vectors.sv
`timescale 1ns / 100ps
// self-checking testbench of the general-direction lorentz boost pipeline
module tb_lorentz_boost_four_vectors
    import lbf_pkg::*;
();

    typedef struct {
        logic [10:0][31:0] w;
    } t_particle;

    typedef struct {
        logic [7:0][31:0] v;
        logic             inv;
    } t_boosted;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wen = 1'b0;
    logic             i_cfg_wdata = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tuser;

    lorentz_boost_four_vectors u_top (.*);

    always #5 i_clk = ~i_clk;

    t_particle pending_particles[$];
    t_boosted  expected_boosts[$];
    logic      coord_boost_mode = 1'b1;
    int        errors = 0;
    int        beats_sent = 0;
    int        beats_seen = 0;
    int        invalid_seen = 0;
    bit        sender_hold = 1'b0;

    // append one particle to the send queue
    function automatic void add_particle(t_particle p);
        pending_particles = {pending_particles, p};
    endfunction

    // saturate a signed value to 32 bits
    function automatic logic [31:0] clamp32(logic signed [191:0] a);
        if (a > 192'sd2147483647) return 32'h7fff_ffff;
        if (a < -192'sd2147483648) return 32'h8000_0000;
        return a[31:0];
    endfunction

    // floor(2^64 / x)
    function automatic logic [63:0] inv64(logic [63:0] x);
        logic [128:0] num;
        num = 129'd1 << 64;
        return 64'(num / x);
    endfunction

    // boost one four-vector by velocity with gamma and k in Q32.32
    function automatic logic [3:0][31:0] boost_vec(logic [3:0][31:0] a,
            logic [2:0][31:0] vel, logic [63:0] g, logic [63:0] k);
        logic signed [191:0] dot, t, c, s;
        logic signed [191:0] gs, ks;
        logic [3:0][31:0] res;
        gs = $signed({128'd0, g});
        ks = $signed({128'd0, k});
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot += 192'($signed(vel[i])) * 192'($signed(a[i+1]));
        t = (192'($signed(a[0])) <<< 30) - dot;
        res[0] = clamp32((gs * t) >>> 62);
        c = (ks * dot - ((gs * 192'($signed(a[0]))) <<< 30)) >>> 46;
        for (int i = 0; i < 3; i++) begin
            s = c * 192'($signed(vel[i])) + (192'($signed(a[i+1])) <<< 46);
            res[i+1] = clamp32(s >>> 46);
        end
        return res;
    endfunction

    // expected outcome of one particle under the current mode
    function automatic t_boosted predict_boost(t_particle p);
        t_boosted r;
        logic [2:0][31:0] vel;
        logic [65:0] v2;
        logic [63:0] rad, sq, g, k;
        logic [127:0] rem, trial;
        vel = p.w[10:8];
        v2 = 0;
        for (int i = 0; i < 3; i++)
            v2 += 66'(64'($signed(vel[i]) * $signed(vel[i])));
        v2 = v2[63:0];
        r.inv = 1'b0;
        r.v = p.w[7:0];
        if (v2 == 0) return r;
        if (v2 >= 66'(ONE_Q60)) begin
            r.v = '0;
            r.inv = 1'b1;
            return r;
        end
        rad = (ONE_Q60 - v2[63:0]) << 4;
        // bitwise integer square root
        sq = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = 128'(sq | (64'd1 << b));
            if (trial * trial <= 128'(rad)) sq = trial[63:0];
        end
        rem = 128'(sq) * 128'(sq);
        g = inv64(sq);
        k = inv64(sq + rem[95:32]);
        r.v[3:0] = boost_vec(p.w[3:0], vel, g, k);
        if (coord_boost_mode) r.v[7:4] = boost_vec(p.w[7:4], vel, g, k);
        return r;
    endfunction

    // accept flag captured at the rising edge
    logic o_s_axis_tready_q = 1'b0;
    always @(posedge i_clk)
        o_s_axis_tready_q <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;

    // driver: one beat per pending particle, random gap before each
    int send_gap = 0;
    always @(negedge i_clk) begin
        t_particle sent;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready_q) begin
                sent = pending_particles.pop_front();
                expected_boosts = {expected_boosts, predict_boost(sent)};
                beats_sent++;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end
            // an offered beat stays up until taken, even when held
            if ((!sender_hold || (i_s_axis_tvalid && !o_s_axis_tready_q))
                    && pending_particles.size() > 0 && send_gap == 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pending_particles[0].w;
            end else begin
                i_s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // result side: random stall per beat, then compare
    int take_gap = 0;
    always @(negedge i_clk) begin
        if (take_gap > 0) begin
            take_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        t_boosted want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            beats_seen++;
            if (o_m_axis_tuser) invalid_seen++;
            if (expected_boosts.size() == 0) begin
                $display("%0t: result beat with none expected, got %h %b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                want = expected_boosts.pop_front();
                for (int i = 0; i < 8; i++)
                    if (o_m_axis_tdata[32*i +: 32] !== want.v[i]) begin
                        $display("%0t: word %0d expected %h got %h", $time, i,
                                 want.v[i], o_m_axis_tdata[32*i +: 32]);
                        errors++;
                    end
                if (o_m_axis_tuser !== want.inv) begin
                    $display("%0t: invalid expected %b got %b", $time, want.inv,
                             o_m_axis_tuser);
                    errors++;
                end
            end
            take_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        end
    end

    // random velocity component, mostly well inside light speed
    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
            1: return $urandom_range(0, 1) ? 32'sd1073741824 : -32'sd1073741824;
            2: return 32'($signed($urandom_range(0, 32)) - 16);
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 1240000000)) - 620000000);
        endcase
    endfunction

    function automatic t_particle rand_particle();
        t_particle p;
        for (int i = 0; i < 8; i++)
            p.w[i] = $urandom_range(0, 2) == 0 ? $urandom
                   : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        for (int i = 8; i < 11; i++) p.w[i] = rand_vel();
        if ($urandom_range(0, 15) == 0) p.w[10:8] = '0;
        return p;
    endfunction

    task automatic drain();
        while (pending_particles.size() > 0 || expected_boosts.size() > 0)
            @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        coord_boost_mode = m;
    endtask

    initial begin
        t_particle p;
        logic [31:0] corner [6];
        corner = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                   32'h0001_0000, 32'h5555_aaaa};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero velocity, light speed, above light speed, field extremes
        for (int i = 0; i < 6; i++) begin
            p.w[7:0] = {8{corner[i]}};
            p.w[10:8] = '0;
            add_particle(p);
            p.w[10:8] = {32'h0, 32'h0, corner[i] == 32'h8000_0000 ? 32'hc000_0000 : 32'h4000_0000};
            add_particle(p);
            p.w[10:8] = {32'h3000_0000, 32'hd000_0000, 32'h2000_0000};
            add_particle(p);
        end
        p.w[10:8] = {32'h4000_0000, 32'h4000_0000, 32'h4000_0000};
        add_particle(p);
        p.w[10:8] = {32'h8000_0000, 32'h7fff_ffff, 32'h0};
        add_particle(p);
        drain();

        // random phases over both modes
        for (int ph = 0; ph < 6; ph++) begin
            set_mode(1'(ph % 2));
            for (int i = 0; i < 150; i++) add_particle(rand_particle());
            // halfway through one phase the sender waits for every result
            if (ph == 3) begin
                while (pending_particles.size() > 75) @(posedge i_clk);
                sender_hold = 1'b1;
                while (expected_boosts.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
                sender_hold = 1'b0;
            end
            drain();
        end
        set_mode(1'b1);
        for (int i = 0; i < 20; i++) add_particle(rand_particle());
        drain();

        $display("covered %0d particles in and %0d results out, %0d of them invalid,",
                 beats_sent, beats_seen, invalid_seen);
        $display("with coordinate boosting both enabled and bypassed");
        if (errors == 0 && expected_boosts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
rtl/lbf_pkg.sv
rtl/lbf_mul.sv
rtl/lbf_recip.sv
rtl/lorentz_boost_four_vectors.sv
verif/tb_lorentz_boost_four_vectors.sv
